[rtl/core/mesi_dmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI direct-mapped cache package
// Shared constants, request codes and line state codes.
// ----------------------------------------------------------------------------
package mesi_dmc_pkg;

	localparam int DEF_OFFSET_BITS    = 3;
	localparam int DEF_INDEX_WIDTH    = 6;
	localparam int DEF_WORDS_PER_LINE = 8;
	localparam int DEF_ADDR_WIDTH     = 21;

	localparam int DATA_W  = 32;
	localparam int REQ_W   = 3;
	localparam int CORE_W  = 2;
	localparam int STATE_W = 2;

	typedef logic [REQ_W-1:0]   req_code_t;
	typedef logic [STATE_W-1:0] mesi_t;

	localparam req_code_t REQ_READ      = 3'd0;
	localparam req_code_t REQ_WRITE     = 3'd1;
	localparam req_code_t REQ_SNOOP_RD  = 3'd2;
	localparam req_code_t REQ_SNOOP_RDX = 3'd3;
	localparam req_code_t REQ_WRITEBACK = 3'd4;
	localparam req_code_t REQ_FILL      = 3'd5;

	localparam mesi_t MESI_I = 2'd0;
	localparam mesi_t MESI_S = 2'd1;
	localparam mesi_t MESI_E = 2'd2;
	localparam mesi_t MESI_M = 2'd3;

	localparam logic CMD_BUSRD  = 1'b0;
	localparam logic CMD_BUSRDX = 1'b1;

endpackage

[rtl/core/mesi_dmc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI cache request channel
// Valid/ready channel carrying one processor, snoop, writeback or fill request.
// ----------------------------------------------------------------------------
interface mesi_dmc_req_if #(
	parameter int ADDR_WIDTH  = mesi_dmc_pkg::DEF_ADDR_WIDTH,
	parameter int INDEX_WIDTH = mesi_dmc_pkg::DEF_INDEX_WIDTH
);
	logic                               valid;
	logic                               ready;
	logic [mesi_dmc_pkg::REQ_W-1:0]     req_type;
	logic [ADDR_WIDTH-1:0]              addr;
	logic signed [mesi_dmc_pkg::DATA_W-1:0] wdata;
	logic [mesi_dmc_pkg::CORE_W-1:0]    requester;
	logic [INDEX_WIDTH-1:0]             line_index;
	logic [mesi_dmc_pkg::STATE_W-1:0]   fill_state;
	logic                               fill_last;

	modport source (
		output valid, req_type, addr, wdata, requester, line_index, fill_state, fill_last,
		input  ready
	);
	modport sink (
		input  valid, req_type, addr, wdata, requester, line_index, fill_state, fill_last,
		output ready
	);
endinterface

[rtl/core/mesi_dmc_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI cache result channel
// Valid/ready channel carrying one result of a request.
// ----------------------------------------------------------------------------
interface mesi_dmc_res_if #(
	parameter int ADDR_WIDTH = mesi_dmc_pkg::DEF_ADDR_WIDTH
);
	logic                                   valid;
	logic                                   ready;
	logic                                   done_res;
	logic signed [mesi_dmc_pkg::DATA_W-1:0] rdata;
	logic                                   bus_req_issued;
	logic                                   bus_cmd;
	logic [ADDR_WIDTH-1:0]                  bus_addr;
	logic                                   shared_hit;
	logic                                   snoop_modified;
	logic [mesi_dmc_pkg::CORE_W-1:0]        owner_core;
	logic [ADDR_WIDTH-1:0]                  wb_addr;
	logic signed [mesi_dmc_pkg::DATA_W-1:0] wb_data;
	logic                                   last;

	modport source (
		output valid, done_res, rdata, bus_req_issued, bus_cmd, bus_addr, shared_hit,
		       snoop_modified, owner_core, wb_addr, wb_data, last,
		input  ready
	);
	modport sink (
		input  valid, done_res, rdata, bus_req_issued, bus_cmd, bus_addr, shared_hit,
		       snoop_modified, owner_core, wb_addr, wb_data, last,
		output ready
	);
endinterface

[rtl/core/mesi_dmc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module mesi_dmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/core/mesi_direct_mapped_cache.sv]
// A taken request is captured, then the lookup state checks tag/state and data
// RAM read data and loads the result register once it is free; a new request is
// taken only in the idle state. A writeback of a Modified line streams one word
// per cycle from the data RAM read port while the result side keeps up.
// Reset: per-line valid flops clear so every line reads Invalid at once, the
// pending flag and the core id clear; data RAM contents stay undefined.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI direct-mapped write-back cache
// Tag/state RAM and data RAM with read-modify-write control and snoop handling.
// ----------------------------------------------------------------------------
module mesi_direct_mapped_cache #(
	parameter int OFFSET_BITS    = mesi_dmc_pkg::DEF_OFFSET_BITS,
	parameter int INDEX_WIDTH    = mesi_dmc_pkg::DEF_INDEX_WIDTH,
	parameter int WORDS_PER_LINE = mesi_dmc_pkg::DEF_WORDS_PER_LINE,
	parameter int ADDR_WIDTH     = mesi_dmc_pkg::DEF_ADDR_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [mesi_dmc_pkg::CORE_W-1:0] cfg_wdata,
	mesi_dmc_req_if.sink                    req,
	mesi_dmc_res_if.source                  res
);
	localparam int TAG_W  = ADDR_WIDTH - OFFSET_BITS - INDEX_WIDTH;
	localparam int META_W = TAG_W + mesi_dmc_pkg::STATE_W;
	localparam int LINES  = 1 << INDEX_WIDTH;
	localparam int WAW    = INDEX_WIDTH + OFFSET_BITS;
	localparam int WORDS  = 1 << WAW;
	localparam int CNT_W  = $clog2(WORDS_PER_LINE);
	localparam int DW     = mesi_dmc_pkg::DATA_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_WOUT = 2'd2;

	logic [1:0] state_q, state_n;

	logic [mesi_dmc_pkg::CORE_W-1:0] own_core_id_q;
	logic                            pending_q;
	logic [LINES-1:0]                valid_q;

	// request capture
	mesi_dmc_pkg::req_code_t         type_q;
	logic [ADDR_WIDTH-1:0]           addr_q;
	logic [DW-1:0]                   wdata_q;
	logic [mesi_dmc_pkg::CORE_W-1:0] reqr_q;
	logic [INDEX_WIDTH-1:0]          idx_q;
	mesi_dmc_pkg::mesi_t             fst_q;
	logic                            flast_q;

	logic [ADDR_WIDTH-1:0] base_q;
	logic [CNT_W-1:0]      cnt_q;

	// output register
	logic                            out_valid_q;
	logic                            out_done_q;
	logic [DW-1:0]                   out_rdata_q;
	logic                            out_iss_q;
	logic                            out_cmd_q;
	logic [ADDR_WIDTH-1:0]           out_baddr_q;
	logic                            out_sh_q;
	logic                            out_mod_q;
	logic [mesi_dmc_pkg::CORE_W-1:0] out_mcore_q;
	logic [ADDR_WIDTH-1:0]           out_wba_q;
	logic [DW-1:0]                   out_wbd_q;
	logic                            out_last_q;

	logic                            n_done, n_iss, n_cmd, n_sh, n_mod, n_last;
	logic [DW-1:0]                   n_rdata, n_wbd;
	logic [ADDR_WIDTH-1:0]           n_baddr, n_wba;
	logic [mesi_dmc_pkg::CORE_W-1:0] n_mcore;

	logic req_acc, out_free, out_load;
	logic set_pending, clr_pending;
	logic latch_base;

	logic [INDEX_WIDTH-1:0] acc_idx;
	logic [WAW-1:0]         acc_waddr;

	logic                meta_we, meta_re;
	logic [META_W-1:0]   meta_wd, meta_rd;
	logic                word_we, word_re;
	logic [WAW-1:0]      word_waddr, word_raddr;
	logic [DW-1:0]       word_wd, word_rd;

	logic [TAG_W-1:0]    tag_rd, tag_q;
	mesi_dmc_pkg::mesi_t st_eff;
	logic                hit, foreign, wb_last;
	logic [CNT_W-1:0]    cnt_inc;

	mesi_dmc_ram #(.WIDTH(META_W), .DEPTH(LINES)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (idx_q),
		.wdata (meta_wd),
		.re    (meta_re),
		.raddr (acc_idx),
		.rdata (meta_rd)
	);

	mesi_dmc_ram #(.WIDTH(DW), .DEPTH(WORDS)) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (word_waddr),
		.wdata (word_wd),
		.re    (word_re),
		.raddr (word_raddr),
		.rdata (word_rd)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;

	assign acc_idx   = (req.req_type == mesi_dmc_pkg::REQ_WRITEBACK) ?
		req.line_index : req.addr[WAW-1:OFFSET_BITS];
	assign acc_waddr = (req.req_type == mesi_dmc_pkg::REQ_WRITEBACK) ?
		{req.line_index, {OFFSET_BITS{1'b0}}} : req.addr[WAW-1:0];

	assign tag_rd  = meta_rd[META_W-1:mesi_dmc_pkg::STATE_W];
	assign tag_q   = addr_q[ADDR_WIDTH-1:WAW];
	assign st_eff  = valid_q[idx_q] ? meta_rd[mesi_dmc_pkg::STATE_W-1:0] : mesi_dmc_pkg::MESI_I;
	assign hit     = (st_eff != mesi_dmc_pkg::MESI_I) && (tag_rd == tag_q);
	assign foreign = (reqr_q != own_core_id_q);
	assign wb_last = (cnt_q == CNT_W'(WORDS_PER_LINE - 1));
	assign cnt_inc = cnt_q + CNT_W'(1);

	assign meta_re    = req_acc;
	assign word_waddr = addr_q[WAW-1:0];
	assign word_raddr = (state_q == ST_IDLE) ? acc_waddr : {idx_q, OFFSET_BITS'(cnt_inc)};
	assign word_re    = req_acc || ((state_q == ST_WOUT) && out_free && !wb_last);

	always_comb begin
		state_n     = state_q;
		out_load    = 1'b0;
		set_pending = 1'b0;
		clr_pending = 1'b0;
		latch_base  = 1'b0;
		meta_we     = 1'b0;
		meta_wd     = meta_rd;
		word_we     = 1'b0;
		word_wd     = wdata_q;
		n_done      = 1'b0;
		n_rdata     = '0;
		n_iss       = 1'b0;
		n_cmd       = mesi_dmc_pkg::CMD_BUSRD;
		n_baddr     = '0;
		n_sh        = 1'b0;
		n_mod       = 1'b0;
		n_mcore     = '0;
		n_wba       = '0;
		n_wbd       = '0;
		n_last      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_n = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (type_q == mesi_dmc_pkg::REQ_WRITEBACK && st_eff == mesi_dmc_pkg::MESI_M) begin
					latch_base = 1'b1;
					state_n    = ST_WOUT;
				end else if (out_free) begin
					out_load = 1'b1;
					state_n  = ST_IDLE;
					unique case (type_q)
						mesi_dmc_pkg::REQ_READ: begin
							if (hit) begin
								n_done  = 1'b1;
								n_rdata = word_rd;
							end else if (!pending_q) begin
								set_pending = 1'b1;
								n_iss       = 1'b1;
								n_cmd       = mesi_dmc_pkg::CMD_BUSRD;
								n_baddr     = {addr_q[ADDR_WIDTH-1:OFFSET_BITS], {OFFSET_BITS{1'b0}}};
							end
						end
						mesi_dmc_pkg::REQ_WRITE: begin
							if (hit && (st_eff == mesi_dmc_pkg::MESI_E ||
							            st_eff == mesi_dmc_pkg::MESI_M)) begin
								word_we = 1'b1;
								meta_we = 1'b1;
								meta_wd = {tag_rd, mesi_dmc_pkg::MESI_M};
								n_done  = 1'b1;
							end else if (!pending_q) begin
								set_pending = 1'b1;
								n_iss       = 1'b1;
								n_cmd       = mesi_dmc_pkg::CMD_BUSRDX;
								n_baddr     = {addr_q[ADDR_WIDTH-1:OFFSET_BITS], {OFFSET_BITS{1'b0}}};
							end
						end
						mesi_dmc_pkg::REQ_SNOOP_RD: begin
							if (foreign && hit) begin
								n_sh = 1'b1;
								if (st_eff == mesi_dmc_pkg::MESI_M) begin
									n_mod   = 1'b1;
									n_mcore = own_core_id_q;
								end
								meta_we = 1'b1;
								meta_wd = {tag_rd, mesi_dmc_pkg::MESI_S};
							end
						end
						mesi_dmc_pkg::REQ_SNOOP_RDX: begin
							if (foreign && hit) begin
								if (st_eff == mesi_dmc_pkg::MESI_M) begin
									n_mod   = 1'b1;
									n_mcore = own_core_id_q;
								end
								meta_we = 1'b1;
								meta_wd = {tag_rd, mesi_dmc_pkg::MESI_I};
							end
						end
						mesi_dmc_pkg::REQ_FILL: begin
							word_we     = 1'b1;
							meta_we     = 1'b1;
							meta_wd     = {tag_q, fst_q};
							clr_pending = flast_q;
							n_done      = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WOUT: begin
				if (out_free) begin
					out_load = 1'b1;
					n_done   = 1'b1;
					n_wba    = base_q + ADDR_WIDTH'(cnt_q);
					n_wbd    = word_rd;
					n_last   = wb_last;
					if (wb_last) begin
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			own_core_id_q <= '0;
			pending_q     <= 1'b0;
			valid_q       <= '0;
			out_valid_q   <= 1'b0;
			cnt_q         <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_wen) begin
				own_core_id_q <= cfg_wdata;
			end
			if (set_pending) begin
				pending_q <= 1'b1;
			end else if (clr_pending) begin
				pending_q <= 1'b0;
			end
			if (meta_we) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (latch_base) begin
				cnt_q <= '0;
			end else if (state_q == ST_WOUT && out_free && !wb_last) begin
				cnt_q <= cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			type_q  <= req.req_type;
			addr_q  <= req.addr;
			wdata_q <= req.wdata;
			reqr_q  <= req.requester;
			idx_q   <= acc_idx;
			fst_q   <= req.fill_state;
			flast_q <= req.fill_last;
		end
		if (latch_base) begin
			base_q <= {tag_rd, idx_q, {OFFSET_BITS{1'b0}}};
		end
		if (out_load) begin
			out_done_q  <= n_done;
			out_rdata_q <= n_rdata;
			out_iss_q   <= n_iss;
			out_cmd_q   <= n_cmd;
			out_baddr_q <= n_baddr;
			out_sh_q    <= n_sh;
			out_mod_q   <= n_mod;
			out_mcore_q <= n_mcore;
			out_wba_q   <= n_wba;
			out_wbd_q   <= n_wbd;
			out_last_q  <= n_last;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.done_res       = out_done_q;
	assign res.rdata          = out_rdata_q;
	assign res.bus_req_issued = out_iss_q;
	assign res.bus_cmd        = out_cmd_q;
	assign res.bus_addr       = out_baddr_q;
	assign res.shared_hit     = out_sh_q;
	assign res.snoop_modified = out_mod_q;
	assign res.owner_core     = out_mcore_q;
	assign res.wb_addr        = out_wba_q;
	assign res.wb_data        = out_wbd_q;
	assign res.last           = out_last_q;

`ifndef SYNTHESIS
	a_take_then_look: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == ST_LOOK))
		else $error("request taken without lookup");

	a_issue_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && n_iss) |=> pending_q)
		else $error("bus request issued without pending flag");

	a_issue_only_idle_bus: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && n_iss) |-> !pending_q)
		else $error("bus request issued while one is pending");

	a_partial_wb_in_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (state_q == ST_WOUT))
		else $error("writeback word shown outside writeback stream");

	a_no_take_during_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WOUT) |-> !req.ready)
		else $error("request taken during writeback");
`endif
endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI direct-mapped cache testbench
// Drives processor, snoop, writeback and fill requests through the request
// channel and checks every result against its typed table row or a cycle-free
// model of the cache that tracks tags, MESI states, line data and the outstanding
// bus request. A short directed table comes first, then random phases under
// different core ids, with bursts of idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb;

	localparam int AW          = mesi_dmc_pkg::DEF_ADDR_WIDTH;
	localparam int PHASE_ITEMS = 110;
	localparam int LONG_HOLD   = 150;
	localparam int SETTLE      = 4;
	localparam int DRAIN       = 30;
	localparam int CYCLE_LIMIT = 400000;

	localparam mesi_dmc_pkg::req_code_t REQ_SPARE_6 = 3'd6;
	localparam mesi_dmc_pkg::req_code_t REQ_SPARE_7 = 3'd7;

	typedef struct packed {
		mesi_dmc_pkg::req_code_t kind;
		logic [AW-1:0]           addr;
		logic signed [31:0]      wdata;
		logic [1:0]              requester;
		logic [5:0]              line_index;
		mesi_dmc_pkg::mesi_t     fill_state;
		logic                    fill_last;
	} cache_req_t;

	typedef struct packed {
		logic               done_res;
		logic signed [31:0] rdata;
		logic               bus_req_issued;
		logic               bus_cmd;
		logic [AW-1:0]      bus_addr;
		logic               shared_hit;
		logic               snoop_modified;
		logic [1:0]         owner_core;
		logic [AW-1:0]      wb_addr;
		logic signed [31:0] wb_data;
		logic               last;
	} cache_res_t;

	typedef struct packed {
		cache_req_t rq;
		logic       typed;
		cache_res_t want;
	} dir_row_t;

	localparam cache_res_t ONLY_LAST  = '{last: 1'b1, default: '0};
	localparam cache_res_t FILL_DONE  = '{done_res: 1'b1, last: 1'b1, default: '0};
	localparam cache_res_t RD_ISSUE_0 = '{bus_req_issued: 1'b1,
		bus_cmd: mesi_dmc_pkg::CMD_BUSRD, last: 1'b1, default: '0};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [mesi_dmc_pkg::CORE_W-1:0] cfg_wdata;

	mesi_dmc_req_if req ();
	mesi_dmc_res_if res ();

	mesi_direct_mapped_cache DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.res       (res)
	);

	always #5 clk = ~clk;

	// cache image
	logic [11:0]         line_tag [64];
	mesi_dmc_pkg::mesi_t line_state [64];
	logic [31:0]         line_ram [512];
	bit                  ram_written [512];
	bit                  bus_pending;
	logic [1:0]          core_id;

	cache_res_t access_results [$];
	dir_row_t   steps [26];
	logic [11:0] tag_pool [4];
	logic [5:0]  idx_pool [8];

	int  mismatches = 0;
	int  cycle_count = 0;
	int  counted_items;
	bit  idle_en = 1'b1;
	bit  hold_off_request = 1'b0;

	initial begin
		foreach (line_tag[i]) begin
			line_tag[i] = '0;
			line_state[i] = mesi_dmc_pkg::MESI_I;
		end
		foreach (line_ram[i]) begin
			line_ram[i] = '0;
			ram_written[i] = 1'b0;
		end
		bus_pending = 1'b0;
		core_id = '0;
	end

	function automatic void raise_request(inout cache_res_t o, input logic cmd,
			input logic [AW-1:0] a);
		if (!bus_pending) begin
			bus_pending = 1'b1;
			o.bus_req_issued = 1'b1;
			o.bus_cmd = cmd;
			o.bus_addr = {a[AW-1:3], 3'b000};
		end
	endfunction

	function automatic void cache_access(input cache_req_t r, output cache_res_t outs[$]);
		logic [5:0]  ix;
		logic [8:0]  sl;
		logic        hit;
		cache_res_t  o;
		ix = r.addr[8:3];
		sl = r.addr[8:0];
		hit = line_state[ix] != mesi_dmc_pkg::MESI_I && line_tag[ix] == r.addr[AW-1:9];
		o = ONLY_LAST;
		outs = {};
		case (r.kind)
			mesi_dmc_pkg::REQ_READ: begin
				if (hit) begin
					o.done_res = 1'b1;
					o.rdata = line_ram[sl];
				end else begin
					raise_request(o, mesi_dmc_pkg::CMD_BUSRD, r.addr);
				end
			end
			mesi_dmc_pkg::REQ_WRITE: begin
				if (hit && (line_state[ix] == mesi_dmc_pkg::MESI_E ||
						line_state[ix] == mesi_dmc_pkg::MESI_M)) begin
					line_ram[sl] = r.wdata;
					ram_written[sl] = 1'b1;
					line_state[ix] = mesi_dmc_pkg::MESI_M;
					o.done_res = 1'b1;
				end else begin
					raise_request(o, mesi_dmc_pkg::CMD_BUSRDX, r.addr);
				end
			end
			mesi_dmc_pkg::REQ_SNOOP_RD, mesi_dmc_pkg::REQ_SNOOP_RDX: begin
				if (r.requester != core_id && hit) begin
					o.shared_hit = (r.kind == mesi_dmc_pkg::REQ_SNOOP_RD);
					if (line_state[ix] == mesi_dmc_pkg::MESI_M) begin
						o.snoop_modified = 1'b1;
						o.owner_core = core_id;
					end
					line_state[ix] = (r.kind == mesi_dmc_pkg::REQ_SNOOP_RD) ?
						mesi_dmc_pkg::MESI_S : mesi_dmc_pkg::MESI_I;
				end
			end
			mesi_dmc_pkg::REQ_WRITEBACK: begin
				if (line_state[r.line_index] == mesi_dmc_pkg::MESI_M) begin
					for (int k = 0; k < 8; k++) begin
						o = '0;
						o.done_res = 1'b1;
						o.wb_addr = {line_tag[r.line_index], r.line_index, 3'(k)};
						o.wb_data = line_ram[{r.line_index, 3'(k)}];
						o.last = (k == 7);
						outs.push_back(o);
					end
					return;
				end
			end
			mesi_dmc_pkg::REQ_FILL: begin
				line_ram[sl] = r.wdata;
				ram_written[sl] = 1'b1;
				line_tag[ix] = r.addr[AW-1:9];
				line_state[ix] = r.fill_state;
				if (r.fill_last)
					bus_pending = 1'b0;
				o.done_res = 1'b1;
			end
			default: ;
		endcase
		outs.push_back(o);
	endfunction

	task automatic issue_request(input cache_req_t r, input logic typed, input cache_res_t want);
		cache_res_t outs [$];
		req.valid <= 1'b1;
		req.req_type <= r.kind;
		req.addr <= r.addr;
		req.wdata <= r.wdata;
		req.requester <= r.requester;
		req.line_index <= r.line_index;
		req.fill_state <= r.fill_state;
		req.fill_last <= r.fill_last;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		cache_access(r, outs);
		if (typed)
			access_results.push_back(want);
		else
			foreach (outs[i])
				access_results.push_back(outs[i]);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	function automatic cache_req_t rand_request(input mesi_dmc_pkg::req_code_t kind,
			input logic [AW-1:0] a);
		cache_req_t r;
		r.kind = kind;
		r.addr = a;
		r.wdata = $urandom;
		r.requester = 2'($urandom);
		r.line_index = 6'($urandom);
		r.fill_state = mesi_dmc_pkg::mesi_t'($urandom);
		r.fill_last = 1'($urandom);
		return r;
	endfunction

	function automatic logic [AW-1:0] pool_addr();
		return {tag_pool[$urandom_range(0, 3)], idx_pool[$urandom_range(0, 7)],
			3'($urandom_range(0, 7))};
	endfunction

	// never read a data word that has not been written: fill it instead
	task automatic send_random(input cache_req_t r);
		logic [5:0] ix;
		int hole;
		ix = r.addr[8:3];
		hole = -1;
		if (r.kind == mesi_dmc_pkg::REQ_READ && line_state[ix] != mesi_dmc_pkg::MESI_I
				&& line_tag[ix] == r.addr[AW-1:9] && !ram_written[r.addr[8:0]]) begin
			r.kind = mesi_dmc_pkg::REQ_FILL;
			r.fill_state = line_state[ix];
			r.fill_last = 1'b0;
		end
		if (r.kind == mesi_dmc_pkg::REQ_WRITEBACK
				&& line_state[r.line_index] == mesi_dmc_pkg::MESI_M) begin
			for (int k = 7; k >= 0; k--)
				if (!ram_written[{r.line_index, 3'(k)}])
					hole = k;
			if (hole >= 0) begin
				r.kind = mesi_dmc_pkg::REQ_FILL;
				r.addr = {line_tag[r.line_index], r.line_index, 3'(hole)};
				r.fill_state = mesi_dmc_pkg::MESI_M;
				r.fill_last = 1'b0;
			end
		end
		issue_request(r, 1'b0, ONLY_LAST);
		if (r.kind <= mesi_dmc_pkg::REQ_FILL)
			counted_items++;
	endtask

	task automatic set_core_id(input logic [1:0] id);
		req.valid <= 1'b0;
		while (access_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= id;
		@(posedge clk);
		cfg_wen <= 1'b0;
		core_id = id;
	endtask

	task automatic report(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got)
			report($sformatf("%s want %h got %h", name, want, got));
	endtask

	always @(posedge clk) begin
		cache_res_t got, want;
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
			got = '{res.done_res, res.rdata, res.bus_req_issued, res.bus_cmd, res.bus_addr,
				res.shared_hit, res.snoop_modified, res.owner_core, res.wb_addr,
				res.wb_data, res.last};
			if (access_results.size() == 0) begin
				report("result with no request outstanding");
			end else begin
				want = access_results.pop_front();
				check_field("done_res", want.done_res, got.done_res);
				check_field("rdata", want.rdata, got.rdata);
				check_field("bus_req_issued", want.bus_req_issued, got.bus_req_issued);
				check_field("bus_cmd", want.bus_cmd, got.bus_cmd);
				check_field("bus_addr", want.bus_addr, got.bus_addr);
				check_field("shared_hit", want.shared_hit, got.shared_hit);
				check_field("snoop_modified", want.snoop_modified, got.snoop_modified);
				check_field("owner_core", want.owner_core, got.owner_core);
				check_field("wb_addr", want.wb_addr, got.wb_addr);
				check_field("wb_data", want.wb_data, got.wb_data);
				check_field("last", want.last, got.last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: ready in random runs, idle bursts, one long hold
	initial begin
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				res.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				res.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [1:0] phase_ids [4];
		cache_req_t r;
		logic [AW-1:0] a;
		mesi_dmc_pkg::mesi_t st;
		int n;

		phase_ids = '{2'd3, 2'd1, 2'd2, 2'd0};
		steps = '{
			'{'{mesi_dmc_pkg::REQ_READ, 21'h000000, 32'sh0, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b1, RD_ISSUE_0},
			'{'{mesi_dmc_pkg::REQ_WRITE, 21'h1FFFFF, 32'sh7FFFFFFF, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b1, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_SNOOP_RD, 21'h1FFFF8, 32'sh0, 2'd1, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b1, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_WRITEBACK, 21'h000000, 32'sh0, 2'd0, 6'd63,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b1, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_FILL, 21'h1FFFF8, 32'sh80000000, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_E, 1'b0}, 1'b1, FILL_DONE},
			'{'{mesi_dmc_pkg::REQ_FILL, 21'h1FFFF9, 32'sh7FFFFFFF, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_E, 1'b0}, 1'b1, FILL_DONE},
			'{'{mesi_dmc_pkg::REQ_FILL, 21'h1FFFFA, 32'shFFFFFFFF, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_E, 1'b0}, 1'b1, FILL_DONE},
			'{'{mesi_dmc_pkg::REQ_FILL, 21'h1FFFFB, 32'sh00000000, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_E, 1'b0}, 1'b1, FILL_DONE},
			'{'{mesi_dmc_pkg::REQ_FILL, 21'h1FFFFC, 32'sh12345678, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_E, 1'b0}, 1'b1, FILL_DONE},
			'{'{mesi_dmc_pkg::REQ_FILL, 21'h1FFFFD, 32'shA5A5A5A5, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_E, 1'b0}, 1'b1, FILL_DONE},
			'{'{mesi_dmc_pkg::REQ_FILL, 21'h1FFFFE, 32'sh5A5A5A5A, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_E, 1'b0}, 1'b1, FILL_DONE},
			'{'{mesi_dmc_pkg::REQ_FILL, 21'h1FFFFF, 32'sh00000001, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_E, 1'b1}, 1'b1, FILL_DONE},
			'{'{mesi_dmc_pkg::REQ_READ, 21'h1FFFF9, 32'sh0, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b0, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_WRITE, 21'h1FFFF8, 32'shDEADBEEF, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b0, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_WRITEBACK, 21'h000000, 32'sh0, 2'd0, 6'd63,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b0, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_SNOOP_RD, 21'h1FFFF8, 32'sh0, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b1, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_SNOOP_RD, 21'h1FFFF8, 32'sh0, 2'd3, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b0, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_WRITE, 21'h1FFFFC, 32'sh0F0F0F0F, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b0, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_READ, 21'h000040, 32'sh0, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b1, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_WRITEBACK, 21'h000000, 32'sh0, 2'd0, 6'd63,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b1, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_SNOOP_RDX, 21'h1FFFF8, 32'sh0, 2'd2, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b0, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_FILL, 21'h000008, 32'sh00000000, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b1}, 1'b1, FILL_DONE},
			'{'{mesi_dmc_pkg::REQ_READ, 21'h000008, 32'sh0, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b0, ONLY_LAST},
			'{'{mesi_dmc_pkg::REQ_FILL, 21'h000100, 32'sh0BADF00D, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_M, 1'b1}, 1'b1, FILL_DONE},
			'{'{mesi_dmc_pkg::REQ_SNOOP_RDX, 21'h000100, 32'sh0, 2'd1, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b0, ONLY_LAST},
			'{'{REQ_SPARE_6, 21'h000000, 32'sh0, 2'd0, 6'd0,
				mesi_dmc_pkg::MESI_I, 1'b0}, 1'b1, ONLY_LAST}
		};

		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_wdata <= '0;
		req.valid <= 1'b0;
		req.req_type <= mesi_dmc_pkg::REQ_READ;
		req.addr <= '0;
		req.wdata <= '0;
		req.requester <= '0;
		req.line_index <= '0;
		req.fill_state <= mesi_dmc_pkg::MESI_I;
		req.fill_last <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_core_id(2'd0);
		foreach (steps[i])
			issue_request(steps[i].rq, steps[i].typed, steps[i].want);

		for (int ph = 0; ph < 4; ph++) begin
			set_core_id(phase_ids[ph]);
			idle_en = (ph != 3);
			if (ph == 1)
				hold_off_request = 1'b1;
			tag_pool = '{12'h000, 12'hFFF, 12'($urandom), 12'($urandom)};
			idx_pool[0] = 6'd0;
			idx_pool[1] = 6'd63;
			for (int i = 2; i < 8; i++)
				idx_pool[i] = 6'($urandom);
			counted_items = 0;
			while (counted_items < PHASE_ITEMS) begin
				n = $urandom_range(0, 19);
				if (n <= 6) begin
					repeat ($urandom_range(1, 4))
						send_random(rand_request($urandom_range(0, 1) ?
							mesi_dmc_pkg::REQ_WRITE : mesi_dmc_pkg::REQ_READ, pool_addr()));
				end else if (n <= 11) begin
					a = pool_addr();
					send_random(rand_request($urandom_range(0, 1) ?
						mesi_dmc_pkg::REQ_WRITE : mesi_dmc_pkg::REQ_READ, a));
					st = ($urandom_range(0, 9) == 0) ? mesi_dmc_pkg::MESI_I :
						mesi_dmc_pkg::mesi_t'($urandom_range(1, 3));
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : 8;
					for (int k = 0; k < n; k++) begin
						r = rand_request(mesi_dmc_pkg::REQ_FILL, {a[AW-1:3], 3'(k)});
						r.fill_state = st;
						r.fill_last = (n == 8) ? (k == 7) : 1'($urandom);
						send_random(r);
					end
				end else if (n <= 14) begin
					repeat ($urandom_range(1, 2))
						send_random(rand_request($urandom_range(0, 1) ?
							mesi_dmc_pkg::REQ_SNOOP_RD : mesi_dmc_pkg::REQ_SNOOP_RDX,
							pool_addr()));
				end else if (n <= 16) begin
					r = rand_request(mesi_dmc_pkg::REQ_WRITEBACK, AW'($urandom));
					r.line_index = idx_pool[$urandom_range(0, 7)];
					send_random(r);
				end else begin
					send_random(rand_request(mesi_dmc_pkg::req_code_t'($urandom_range(0, 7)),
						AW'($urandom)));
				end
			end
		end

		req.valid <= 1'b0;
		while (access_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && access_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
